[rtl/core/rational_arithmetic_unit_defines.svh]
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// implication checked on every clock, off during reset
`define RAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Opcodes, status codes and shared widths.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned DEF_WIDTH = 32;
    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned DEN_W     = 31;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_EQ  = 3'd5,
        OP_LT  = 3'd6,
        OP_NOP = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSV  = 2'd3
    } status_t;

endpackage

[rtl/core/rau_mul.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Registered unsigned WIDTH x WIDTH magnitude multiplier.
// ----------------------------------------------------------------------------
module rau_mul #(
    parameter int unsigned WIDTH = 32
) (
    input  logic               clk,
    input  logic [WIDTH-1:0]   x,
    input  logic [WIDTH-1:0]   y,
    output logic [2*WIDTH-1:0] p
);
    logic [2*WIDTH-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= x * y;
    end

    assign p = p_reg;
endmodule

[rtl/core/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Works on one item at a time; in_ready is low from acceptance until the result
// item is taken. Errors and the unused opcode give their result in the cycle
// after acceptance. Cross products go through a single registered multiplier,
// then a combine state; compares give their result after the combine.
// Arithmetic results then take a gcd load, a binary gcd at one shift or
// subtract per cycle, two restoring divisions by the gcd (numerator, then
// denominator) and a check state.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
    parameter int unsigned WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    opcode,
    input  logic signed [rau_pkg::FIELD_W-1:0] a_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] a_den,
    input  logic signed [rau_pkg::FIELD_W-1:0] b_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] b_den,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [rau_pkg::FIELD_W-1:0] res_num,
    output logic [rau_pkg::DEN_W-1:0]     res_den,
    output logic                          truth,
    output logic [1:0]                    status
);
    import rau_pkg::*;

    localparam int unsigned W2  = 2 * WIDTH;
    localparam int unsigned CW  = $clog2(W2 + 1);
    localparam int unsigned BW  = $clog2(W2);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_COMB  = 9'b000000100,
        S_GSH   = 9'b000001000,
        S_GODD  = 9'b000010000,
        S_GLOOP = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_CHK   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]       op_reg;
    logic             an_s_reg, bn_s_reg;
    logic [WIDTH-1:0] am_reg, ad_reg, bm_reg, bd_reg;
    logic [1:0]       mc_reg;
    logic             mph_reg;
    logic [W2-1:0]    p0_reg, p1_reg, p2_reg;
    logic             nneg_reg;
    logic [W2-1:0]    nm_reg, dm_reg;
    logic [W2-1:0]    u_reg, v_reg;
    logic [CW-1:0]    k_reg;
    logic             dsel_reg;
    logic [CW-1:0]    bit_reg;
    logic [W2-1:0]    quo_reg, rem_reg;
    logic             load_g_reg;

    logic signed [FIELD_W-1:0] onum_reg;
    logic [DEN_W-1:0]          oden_reg;
    logic                      otr_reg;
    logic [1:0]                ost_reg;

    logic [WIDTH-1:0] mx, my;
    logic [W2-1:0]    prod;

    rau_mul #(.WIDTH(WIDTH)) u_mul (
        .clk (clk),
        .x   (mx),
        .y   (my),
        .p   (prod)
    );

    function automatic logic [WIDTH:0] mag_of(input logic [FIELD_W-1:0] f);
        logic [WIDTH-1:0] raw;
        logic [WIDTH:0]   r;
        begin
            raw = f[WIDTH-1:0];
            if (raw[WIDTH-1])
                r = {1'b1, (~raw) + {{(WIDTH-1){1'b0}}, 1'b1}};
            else
                r = {1'b0, raw};
            return r;
        end
    endfunction

    logic [WIDTH:0] an_f, ad_f, bn_f, bd_f;
    assign an_f = mag_of(a_num);
    assign ad_f = mag_of(a_den);
    assign bn_f = mag_of(b_num);
    assign bd_f = mag_of(b_den);

    // magnitude -2^(W-1) has raw bits 100..0, mag_of gives that with sign set
    logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
    assign an_m = an_f[WIDTH-1:0];
    assign ad_m = ad_f[WIDTH-1:0];
    assign bn_m = bn_f[WIDTH-1:0];
    assign bd_m = bd_f[WIDTH-1:0];

    // products: 0 a*bd, 1 b*ad (mul: a*b), 2 ad*bd, 3 ad*b (div uses 0 and 3)
    always_comb
    begin
        unique case (mc_reg)
            2'd0:    begin mx = am_reg; my = bd_reg; end
            2'd1:    begin mx = (op_reg == OP_MUL) ? am_reg : bm_reg; my = (op_reg == OP_MUL) ? bm_reg : ad_reg; end
            2'd2:    begin mx = ad_reg; my = bd_reg; end
            default: begin mx = ad_reg; my = bm_reg; end
        endcase
    end

    logic [W2-1:0] lim_pos, lim_neg;
    assign lim_neg = {{(W2-WIDTH){1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};
    assign lim_pos = lim_neg - {{(W2-1){1'b0}}, 1'b1};

    logic [BW-1:0] bidx;
    assign bidx = BW'(bit_reg - CW'(1));

    logic [W2-1:0] dvs, rem_sh;
    assign dvs    = u_reg << k_reg;
    assign rem_sh = {rem_reg[W2-2:0], (dsel_reg ? dm_reg[bidx] : nm_reg[bidx])};

    logic acc_in, acc_out;
    assign in_ready = (state_reg == S_IDLE);
    assign acc_in   = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign acc_out  = out_valid && out_ready;

    logic aneg_w, bneg_w;
    assign aneg_w = an_f[WIDTH] ^ ad_f[WIDTH];
    assign bneg_w = bn_f[WIDTH] ^ bd_f[WIDTH];

    logic last_mul;
    always_comb
    begin
        unique case (op_reg)
            OP_ADD, OP_SUB: last_mul = (mc_reg == 2'd2);
            OP_MUL:         last_mul = (mc_reg == 2'd2);
            OP_DIV:         last_mul = (mc_reg == 2'd3);
            default:        last_mul = (mc_reg == 2'd1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (opcode == OP_NOP || ad_m == '0 ||
                        (opcode != OP_NEG && bd_m == '0) ||
                        (opcode == OP_DIV && bn_m == '0) || opcode == OP_NEG)
                        state_next = (opcode == OP_NEG && ad_m != '0) ? S_COMB : S_OUT;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:   if (mph_reg && last_mul) state_next = S_COMB;
            S_COMB:  state_next = (op_reg == OP_EQ || op_reg == OP_LT) ? S_OUT : S_GSH;
            S_GSH:   if (nm_reg == '0) state_next = S_OUT;
                     else if (!load_g_reg && (u_reg[0] || v_reg[0])) state_next = S_GODD;
            S_GODD:  if (u_reg[0]) state_next = S_GLOOP;
            S_GLOOP: if (v_reg == '0) state_next = S_DIV;
            S_DIV:   if (bit_reg == '0 && dsel_reg) state_next = S_CHK;
            S_CHK:   state_next = S_OUT;
            S_OUT:   if (acc_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg   <= opcode;
                am_reg   <= an_m;
                ad_reg   <= ad_m;
                bm_reg   <= bn_m;
                bd_reg   <= bd_m;
                an_s_reg <= aneg_w;
                bn_s_reg <= bneg_w;
                mph_reg  <= 1'b0;
                mc_reg   <= (opcode == OP_MUL) ? 2'd1 : 2'd0;
                onum_reg <= '0;
                oden_reg <= '0;
                otr_reg  <= 1'b0;
                if (opcode == OP_NOP)
                    ost_reg <= ST_OK;
                else if (ad_m == '0 || (opcode != OP_NEG && bd_m == '0) ||
                         (opcode == OP_DIV && bn_m == '0))
                    ost_reg <= ST_ZERO;
                else
                    ost_reg <= ST_OK;
                nneg_reg <= ~aneg_w;
                nm_reg   <= {{WIDTH{1'b0}}, an_m};
                dm_reg   <= {{WIDTH{1'b0}}, ad_m};
            end
            S_MUL:
            begin
                mph_reg <= ~mph_reg;
                if (mph_reg)
                begin
                    unique case (mc_reg)
                        2'd0:    p0_reg <= prod;
                        2'd1:    p1_reg <= prod;
                        default: p2_reg <= prod;
                    endcase
                    if (op_reg == OP_MUL)
                        mc_reg <= 2'd2;
                    else if (op_reg == OP_DIV)
                        mc_reg <= 2'd3;
                    else
                        mc_reg <= mc_reg + 2'd1;
                end
            end
            S_COMB:
            begin
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        if (an_s_reg == (bn_s_reg ^ (op_reg == OP_SUB)))
                        begin
                            nneg_reg <= an_s_reg;
                            nm_reg   <= p0_reg + p1_reg;
                        end
                        else if (p0_reg >= p1_reg)
                        begin
                            nneg_reg <= an_s_reg;
                            nm_reg   <= p0_reg - p1_reg;
                        end
                        else
                        begin
                            nneg_reg <= ~an_s_reg;
                            nm_reg   <= p1_reg - p0_reg;
                        end
                        dm_reg <= p2_reg;
                    end
                    OP_MUL:
                    begin
                        nneg_reg <= an_s_reg ^ bn_s_reg;
                        nm_reg   <= p1_reg;
                        dm_reg   <= p2_reg;
                    end
                    OP_DIV:
                    begin
                        nneg_reg <= an_s_reg ^ bn_s_reg;
                        nm_reg   <= p0_reg;
                        dm_reg   <= p2_reg;
                    end
                    OP_EQ, OP_LT:
                    begin
                        if ((an_s_reg && p0_reg != '0) != (bn_s_reg && p1_reg != '0))
                            otr_reg <= (op_reg == OP_LT) && an_s_reg && p0_reg != '0;
                        else if (p0_reg == p1_reg)
                            otr_reg <= (op_reg == OP_EQ);
                        else if (op_reg == OP_EQ)
                            otr_reg <= 1'b0;
                        else if (an_s_reg && p0_reg != '0)
                            otr_reg <= p0_reg > p1_reg;
                        else
                            otr_reg <= p0_reg < p1_reg;
                    end
                    default: ;
                endcase
            end
            S_GSH:
            begin
                if (nm_reg == '0)
                    oden_reg <= {{(DEN_W-1){1'b0}}, 1'b1};
                if (load_g_reg)
                begin
                    u_reg <= nm_reg;
                    v_reg <= dm_reg;
                    k_reg <= '0;
                end
                else if (!(u_reg[0] || v_reg[0]))
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + CW'(1);
                end
            end
            S_GODD:
                if (!u_reg[0]) u_reg <= u_reg >> 1;
            S_GLOOP:
            begin
                if (v_reg != '0)
                begin
                    if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (u_reg > v_reg)
                    begin
                        u_reg <= v_reg;
                        v_reg <= u_reg - v_reg;
                    end
                    else
                        v_reg <= v_reg - u_reg;
                end
                bit_reg  <= CW'(W2);
                dsel_reg <= 1'b0;
                rem_reg  <= '0;
            end
            S_DIV:
            begin
                if (bit_reg != '0)
                begin
                    if (rem_sh >= dvs)
                    begin
                        rem_reg <= rem_sh - dvs;
                        quo_reg <= {quo_reg[W2-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[W2-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - CW'(1);
                end
                else if (!dsel_reg)
                begin
                    nm_reg   <= quo_reg;
                    bit_reg  <= CW'(W2);
                    rem_reg  <= '0;
                    dsel_reg <= 1'b1;
                end
            end
            S_CHK:
            begin
                if (quo_reg > lim_pos || nm_reg > (nneg_reg ? lim_neg : lim_pos))
                    ost_reg <= ST_OVF;
                else
                begin
                    onum_reg <= nneg_reg ? -FIELD_W'(nm_reg) : FIELD_W'(nm_reg);
                    oden_reg <= DEN_W'(quo_reg);
                end
            end
            default: ;
        endcase
    end

    // gcd operand load: first cycle after combine, from nm/dm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_g_reg <= 1'b0;
        else
            load_g_reg <= (state_reg == S_COMB);
    end

    assign res_num = onum_reg;
    assign res_den = oden_reg;
    assign truth   = otr_reg;
    assign status  = ost_reg;

    `RAU_ASSERT_IMPL(a_busy_not_ready, state_reg != S_IDLE, !in_ready)
    `RAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_num))
    `RAU_ASSERT_IMPL(a_cmp_no_frac, out_valid && (op_reg == OP_EQ || op_reg == OP_LT), res_den == '0)
endmodule

[tb/sv/tb_rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed and random fraction items through the valid/ready input,
// predicts each reduced result with an independent model of the arithmetic,
// and checks every result item field by field under random stalls.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } frac_item_t;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        truth;
        logic [1:0]  status;
    } frac_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic signed [31:0] a_num, a_den, b_num, b_den;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic        truth;
    logic [1:0]  status;

    frac_item_t pending_items[$];
    frac_res_t  expected_results[$];
    int         error_count;
    int         cycle_count;
    int         hold_off;
    int         in_gap;

    rational_arithmetic_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den), .truth(truth), .status(status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] gcd_u64(logic [63:0] u, logic [63:0] v);
        logic [63:0] t;
        while (v != 0)
        begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    // sign/magnitude views, 32-bit fields are full width
    function automatic logic [63:0] mag_of(logic [31:0] x);
        logic [31:0] m;
        m = x[31] ? (~x + 32'd1) : x;
        return {32'b0, m};
    endfunction

    function automatic frac_res_t predict_fraction(frac_item_t it);
        frac_res_t   r;
        logic [63:0] anm, adm, bnm, bdm, t1, t2, nm, d, g;
        logic        aneg, bneg, nneg, t2neg;
        logic signed [65:0] s1, s2;
        r = '0;
        if (it.op == OP_NOP)
            return r;
        if (it.ad == 0 || (it.op != OP_NEG && it.bd == 0))
        begin
            r.status = ST_ZERO;
            return r;
        end
        anm = mag_of(it.an); adm = mag_of(it.ad);
        bnm = mag_of(it.bn); bdm = mag_of(it.bd);
        aneg = it.an[31] ^ it.ad[31];
        bneg = it.bn[31] ^ it.bd[31];
        t1 = anm * bdm;
        t2 = bnm * adm;
        s1 = aneg ? -$signed({2'b0, t1}) : $signed({2'b0, t1});
        s2 = bneg ? -$signed({2'b0, t2}) : $signed({2'b0, t2});
        case (it.op)
            OP_EQ, OP_LT:
            begin
                r.truth = (it.op == OP_EQ) ? (s1 == s2) : (s1 < s2);
                return r;
            end
            OP_ADD, OP_SUB:
            begin
                t2neg = (it.op == OP_SUB) ? ~bneg : bneg;
                s2 = t2neg ? -$signed({2'b0, t2}) : $signed({2'b0, t2});
                s1 = s1 + s2;
                nneg = s1 < 0;
                nm = nneg ? 64'(-s1) : 64'(s1);
                d = adm * bdm;
            end
            OP_MUL:
            begin
                nneg = aneg ^ bneg;
                nm = anm * bnm;
                d = adm * bdm;
            end
            OP_DIV:
            begin
                if (bnm == 0)
                begin
                    r.status = ST_ZERO;
                    return r;
                end
                nneg = aneg ^ bneg;
                nm = t1;
                d = adm * bnm;
            end
            default:
            begin
                nneg = ~aneg;
                nm = anm;
                d = adm;
            end
        endcase
        if (nm == 0)
        begin
            r.den = 1;
            return r;
        end
        g = gcd_u64(nm, d);
        nm = nm / g;
        d = d / g;
        if (d > 64'h7FFF_FFFF || nm > (nneg ? 64'h8000_0000 : 64'h7FFF_FFFF))
        begin
            r.status = ST_OVF;
            return r;
        end
        r.num = nneg ? 32'(-nm) : 32'(nm);
        r.den = 31'(d);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 2);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            3: return 32'($urandom_range(0, 2000)) - 32'd1000;
            4: return $urandom();
            default: return 32'($urandom_range(1, 300)) * 32'($urandom_range(1, 60));
        endcase
    endfunction

    task automatic queue_item(op_t op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
        pending_items.push_back('{op, an, ad, bn, bd});
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
            opcode <= '0;
            a_num <= '0; a_den <= '0; b_num <= '0; b_den <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_results.push_back(predict_fraction(
                    '{op_t'(opcode), a_num, a_den, b_num, b_den}));
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                frac_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                opcode <= it.op;
                a_num <= it.an; a_den <= it.ad; b_num <= it.bn; b_den <= it.bd;
            end
            else
            begin
                in_valid <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    in_gap <= $urandom_range(20, 120);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected item", 0, 0);
                else
                begin
                    frac_res_t e;
                    e = expected_results.pop_front();
                    if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
                    if (res_den !== e.den) report_mismatch("res_den", res_den, e.den);
                    if (truth !== e.truth) report_mismatch("truth", truth, e.truth);
                    if (status !== e.status) report_mismatch("status", status, e.status);
                end
            end
            if (cycle_count == 3000)
            begin
                hold_off <= 2000;
                out_ready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: hold_off <= $urandom_range(20, 150);
                    1, 2, 3: hold_off <= $urandom_range(1, 4);
                    default: ;
                endcase
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] den;
        error_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_item(OP_ADD, 1, 2, 1, 3);
        queue_item(OP_SUB, 1, 2, 1, 2);
        queue_item(OP_MUL, -3, 4, 8, -9);
        queue_item(OP_DIV, 5, 7, 10, 21);
        queue_item(OP_NEG, 6, -4, 0, 0);
        queue_item(OP_EQ, 2, 4, -1, -2);
        queue_item(OP_LT, -1, 3, 1, -4);
        queue_item(OP_LT, 1, 3, 1, 2);
        queue_item(OP_NOP, 5, 5, 5, 5);
        queue_item(OP_ADD, 1, 0, 1, 1);
        queue_item(OP_EQ, 1, 1, 1, 0);
        queue_item(OP_DIV, 3, 1, 0, 5);
        queue_item(OP_NEG, 32'h8000_0000, 1, 0, 0);
        queue_item(OP_NEG, 32'h8000_0000, -1, 0, 0);
        queue_item(OP_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        queue_item(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        queue_item(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1);
        queue_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_item(OP_ADD, 0, 5, 0, -7);
        queue_item(OP_MUL, 1, 32'h10000, 1, 32'h10000);
        queue_item(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 540; i++)
        begin
            den = rand_field();
            if (den == 0 && $urandom_range(0, 3) != 0)
                den = 1;
            queue_item(op_t'($urandom_range(0, 15) == 0 ? 7 : $urandom_range(0, 6)),
                       rand_field(), den, rand_field(),
                       $urandom_range(0, 3) == 0 ? 32'd1 : rand_field());
        end

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
